// ----- rtl/double_ended_queue_unit_defines.svh -----
// Assertion macros shared by the deque unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dq_pkg.sv -----
package dq_pkg;

    typedef enum logic [2:0] {
        CMD_QUERY      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_CLEAR      = 3'd5
    } dq_cmd_e_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } dq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;   // input word accepted this cycle
        logic fill;   // memory read data is valid, load it
    } dq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;  // the offered command must refill front or back from memory
    } dq_stat_t;

endpackage

// ----- rtl/dq_ctrl.sv -----
`include "double_ended_queue_unit_defines.svh"

module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dq_stat_t stat,
    output dq_ctl_t  ctl
);

    dq_state_t state_reg;
    dq_state_t state_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        take           = in_valid && in_ready;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctl.take       = take;
        ctl.fill       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (stat.need_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // read data lands now; publish the result
                ctl.fill       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `DQ_ASSERT_SAME(a_read_no_result, clk, rst_n, state_reg == ST_READ, !out_valid_reg,
        "result pending while a memory read is in flight")
    `DQ_ASSERT_NEXT(a_read_enters, clk, rst_n, take && stat.need_read, state_reg == ST_READ,
        "refilling command did not enter the read state")
    `DQ_ASSERT_NEXT(a_read_completes, clk, rst_n, state_reg == ST_READ,
        (state_reg == ST_IDLE) && out_valid_reg, "read state did not produce a result")

endmodule

// ----- rtl/dq_datapath.sv -----
`include "double_ended_queue_unit_defines.svh"

module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dq_ctl_t             ctl,
    output dq_stat_t            stat,
    input  logic [2:0]          command,
    input  logic signed [31:0]  push_value,
    output logic signed [31:0]  popped_value,
    output logic                error,
    output logic [10:0]         count,
    output logic signed [31:0]  front_value,
    output logic signed [31:0]  back_value,
    output logic                empty_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_IDX : a - AW'(1);
    endfunction

    logic [WORD_BITS-1:0] slot_mem [DEPTH];

    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [WORD_BITS-1:0] front_reg, front_next;
    logic [WORD_BITS-1:0] back_reg, back_next;
    logic [31:0]          popped_reg, popped_next;
    logic                 error_reg, error_next;
    logic                 pend_front_reg, pend_front_next;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [WORD_BITS-1:0] word_in;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 is_empty;
    logic                 is_full;

    assign word_in  = WORD_BITS'(push_value);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    assign stat.need_read = ((command == CMD_POP_FRONT) || (command == CMD_POP_BACK))
                            && (count_reg > CW'(1));

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        popped_next     = popped_reg;
        error_next      = error_reg;
        pend_front_next = pend_front_reg;
        mem_we          = 1'b0;
        wr_addr         = head_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        if (ctl.take)
        begin
            popped_next = '0;
            error_next  = 1'b0;
            unique case (command)
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = idx_dec(head_reg);
                        mem_we     = 1'b1;
                        wr_addr    = idx_dec(head_reg);
                        front_next = word_in;
                        if (is_empty)
                        begin
                            back_next = word_in;
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        tail_next = idx_inc(tail_reg);
                        mem_we    = 1'b1;
                        wr_addr   = idx_inc(tail_reg);
                        back_next = word_in;
                        if (is_empty)
                        begin
                            front_next = word_in;
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        popped_next     = 32'(front_reg);
                        head_next       = idx_inc(head_reg);
                        count_next      = count_reg - CW'(1);
                        rd_en           = 1'b1;
                        rd_addr         = idx_inc(head_reg);
                        pend_front_next = 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        popped_next     = 32'(back_reg);
                        tail_next       = idx_dec(tail_reg);
                        count_next      = count_reg - CW'(1);
                        rd_en           = 1'b1;
                        rd_addr         = idx_dec(tail_reg);
                        pend_front_next = 1'b0;
                    end
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = LAST_IDX;
                    count_next = '0;
                end
                default:
                begin
                    // query and unused codes: a peek fails on an empty queue
                    error_next = is_empty;
                end
            endcase
        end
        if (ctl.fill)
        begin
            if (pend_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                back_next = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= LAST_IDX;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        back_reg   <= back_next;
        popped_reg <= popped_next;
        error_reg  <= error_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= word_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign popped_value = popped_reg;
    assign error        = error_reg;
    assign count        = 11'(count_reg);
    assign front_value  = is_empty ? '0 : 32'(front_reg);
    assign back_value   = is_empty ? '0 : 32'(back_reg);
    assign empty_res    = is_empty;

    `DQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT,
        "held count exceeds depth")
    `DQ_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctl.take && (command == CMD_CLEAR),
        (count_reg == '0) && !error_reg, "clear did not empty the queue")
    `DQ_ASSERT_NEXT(a_pop_empty_err, clk, rst_n,
        ctl.take && ((command == CMD_POP_FRONT) || (command == CMD_POP_BACK)) && is_empty,
        error_reg && (count_reg == '0), "pop on empty queue not flagged")

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// Push, clear, query and a pop leaving no word behind: the result is registered in the cycle after accept.
// A pop that leaves words behind: the command passes through the read state (memory read) before its result.
// Throughput: one word per cycle for non-refilling commands while out_ready stays high; a refilling pop
// blocks new commands until the refill read of the slot memory has completed.
// Reset (rst_n low, async): head and count cleared, tail set to the last slot, queue empty;
// memory is not cleared.
module double_ended_queue_unit
    import dq_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] push_value,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] popped_value,
    output logic               error,
    output logic [10:0]        count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic               empty_res
);

    // Control and datapath talk only through these two bundles.
    // The controller owns the handshakes and the result-valid flag; the
    // datapath holds the head/tail/count registers, cached front and back
    // words, and the slot memory. Front and back are kept in registers so a
    // push never needs a read; a pop returns the cached word and refills the
    // cache from memory when words remain.
    dq_ctl_t  ctl;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Result fields hold steady while out_valid waits: state only advances
    // on the next accepted word, which cannot happen before the result is taken.
    dq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .command      (command),
        .push_value   (push_value),
        .popped_value (popped_value),
        .error        (error),
        .count        (count),
        .front_value  (front_value),
        .back_value   (back_value),
        .empty_res    (empty_res)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top
    import dq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 1024;
    localparam int WORD_BITS    = 32;
    localparam int RANDOM_WORDS = 120;
    localparam int DRAIN_POPS   = 8;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_CAP   = 40;

    // Codes 6 and 7 are outside the command enum; the block reads them as a query.
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    typedef struct packed {
        logic signed [31:0] popped;
        logic               err;
        logic [10:0]        cnt;
        logic signed [31:0] front;
        logic signed [31:0] back;
        logic               empty;
    } deque_result_t;

    // Shadow deque plus the queue of results still owed by the block.
    class deque_scoreboard;
        logic [31:0]   slots [DEPTH];
        int            head;
        int            held;
        int            failures;
        deque_result_t owed_q [$];

        function new();
            head     = 0;
            held     = 0;
            failures = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted command to the shadow deque and queue its result.
        function void note_word(logic [2:0] cmd, logic [31:0] word);
            deque_result_t r;
            r = '0;
            case (cmd)
                CMD_PUSH_FRONT:
                    if (held >= DEPTH) r.err = 1'b1;
                    else
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = word;
                        held++;
                    end
                CMD_PUSH_BACK:
                    if (held >= DEPTH) r.err = 1'b1;
                    else
                    begin
                        slots[(head + held) % DEPTH] = word;
                        held++;
                    end
                CMD_POP_FRONT:
                    if (held == 0) r.err = 1'b1;
                    else
                    begin
                        r.popped = slots[head];
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                CMD_POP_BACK:
                    if (held == 0) r.err = 1'b1;
                    else
                    begin
                        r.popped = slots[(head + held - 1) % DEPTH];
                        held--;
                    end
                CMD_CLEAR:
                begin
                    head = 0;
                    held = 0;
                end
                default:
                    if (held == 0) r.err = 1'b1;
            endcase
            if (held != 0)
            begin
                r.front = slots[head];
                r.back  = slots[(head + held - 1) % DEPTH];
            end
            r.cnt   = 11'(held);
            r.empty = (held == 0);
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void flag_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one delivered result with the oldest owed one.
        function void check_result(deque_result_t got);
            deque_result_t want;
            if (owed_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = owed_q[0];
            owed_q.delete(0);
            flag_field("popped_value", want.popped, got.popped);
            flag_field("error", 32'(want.err), 32'(got.err));
            flag_field("count", 32'(want.cnt), 32'(got.cnt));
            flag_field("front_value", want.front, got.front);
            flag_field("back_value", want.back, got.back);
            flag_field("empty_res", 32'(want.empty), 32'(got.empty));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         command;
    logic signed [31:0] push_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] popped_value;
    logic               error;
    logic [10:0]        count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               empty_res;

    deque_scoreboard sb;
    logic            calm;        // when set, the sender inserts no idle cycles and the receiver starts no new stall
    int              words_sent;

    double_ended_queue_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .error        (error),
        .count        (count),
        .front_value  (front_value),
        .back_value   (back_value),
        .empty_res    (empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length: mostly none or a few cycles, now and then a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bias toward the extremes of a signed word, otherwise any pattern.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Mostly pushes and pops so the depth wanders; clear, query and unused codes now and then.
    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return CMD_PUSH_FRONT;
        if (r < 50) return CMD_PUSH_BACK;
        if (r < 68) return CMD_POP_FRONT;
        if (r < 86) return CMD_POP_BACK;
        if (r < 93) return CMD_QUERY;
        if (r < 96) return CMD_CLEAR;
        return ($urandom_range(0, 1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
    endfunction

    // Offer one word, after an optional idle stretch, and hold it until taken.
    task automatic send_word(logic [2:0] cmd, logic [31:0] word);
        int gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        push_value <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and hold off until every owed result has been delivered.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        // Peek and pop on an empty deque must all flag an error.
        send_word(CMD_QUERY, 32'h0);
        send_word(CMD_POP_FRONT, 32'h0);
        send_word(CMD_POP_BACK, 32'h0);
        // Push front from head zero wraps the head to the top slot.
        send_word(CMD_PUSH_FRONT, 32'h7fff_ffff);
        send_word(CMD_PUSH_BACK, 32'h8000_0000);
        send_word(CMD_PUSH_FRONT, 32'h0000_0000);
        send_word(CMD_PUSH_BACK, 32'hffff_ffff);
        send_word(CMD_QUERY, 32'h1234_5678);
        send_word(CMD_UNUSED_A, 32'h5555_5555);
        send_word(CMD_UNUSED_B, 32'haaaa_aaaa);
        send_word(CMD_POP_FRONT, 32'h0);
        send_word(CMD_POP_BACK, 32'h0);
        // Clear with words still held, then make sure the old words stay hidden.
        send_word(CMD_CLEAR, 32'h0);
        send_word(CMD_QUERY, 32'h0);
        send_word(CMD_POP_BACK, 32'h0);
        send_word(CMD_PUSH_BACK, 32'h0000_0001);
        send_word(CMD_PUSH_FRONT, 32'hfedc_ba98);
        send_word(CMD_POP_BACK, 32'h0);
        send_word(CMD_POP_FRONT, 32'h0);
        send_word(CMD_POP_FRONT, 32'h0);
        send_word(CMD_CLEAR, 32'h0);
    endtask

    // Fill to the brim, knock on the full deque, pop a few, then clear.
    task automatic run_fill();
        calm = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH / 2) calm = 1'b0;
            send_word(($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
        end
        send_word(CMD_PUSH_FRONT, pick_word());
        send_word(CMD_PUSH_BACK, pick_word());
        send_word(CMD_QUERY, 32'h0);
        send_word(CMD_POP_FRONT, 32'h0);
        send_word(CMD_PUSH_BACK, pick_word());
        send_word(CMD_PUSH_FRONT, pick_word());
        send_word(CMD_POP_BACK, 32'h0);
        send_word(CMD_PUSH_FRONT, pick_word());
        send_word(CMD_PUSH_BACK, pick_word());
        for (int i = 0; i < DRAIN_POPS; i++)
            send_word(($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK, 32'h0);
        send_word(CMD_CLEAR, 32'h0);
    endtask

    // Segments of mixed traffic, push and pop bursts, and raw noise.
    task automatic run_random();
        int start;
        int seg;
        int len;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            seg  = $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(1, 40);
            case (seg)
                4, 5:
                    repeat (len * 2)
                        send_word(($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                  pick_word());
                6, 7:
                    repeat (len)
                        send_word(($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK,
                                  pick_word());
                8:
                    repeat (len)
                        send_word(3'($urandom_range(CMD_QUERY, CMD_UNUSED_B)), $urandom());
                9:
                begin
                    wait_for_drain();
                    repeat (len) send_word(pick_command(), pick_word());
                end
                default:
                    repeat (len) send_word(pick_command(), pick_word());
            endcase
        end
        calm = 1'b0;
    endtask

    // Note every word the block takes.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_word(command, push_value);
    end

    // Check every result the block hands over.
    always @(posedge clk)
    begin : result_monitor
        deque_result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.popped = popped_value;
            seen.err    = error;
            seen.cnt    = count;
            seen.front  = front_value;
            seen.back   = back_value;
            seen.empty  = empty_res;
            sb.check_result(seen);
        end
    end

    // Receiver: stall for random stretches unless the calm flag is up.
    initial
    begin : result_sink
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watchdog: end the run if it is still going far past the slowest legal run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("double_ended_queue_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_QUERY;
        push_value <= '0;
        calm        = 1'b0;
        words_sent  = 0;
        sb          = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_drain();
        run_fill();
        wait_for_drain();
        run_random();
        wait_for_drain();

        // Advance a few more cycles so any stray result still shows up.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("double_ended_queue_unit verification clean");
        else
            $display("double_ended_queue_unit verification failed");
        $finish;
    end

endmodule

// ----- double_ended_queue_unit.f -----
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue_unit.sv
dv/tb_top.sv
